// ===== hw/rtl/wsfe_pkg.sv =====
package wsfe_pkg;

	// Input command codes.
	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_PAYLOAD = 1'b1;

	// Header length classes, chosen by the front end from the frame length.
	localparam logic [1:0] LEN_CLASS_SHORT = 2'd0;
	localparam logic [1:0] LEN_CLASS_16    = 2'd1;
	localparam logic [1:0] LEN_CLASS_64    = 2'd2;

	// Length thresholds and header marks.
	localparam logic [31:0] LEN_SHORT_LIMIT = 32'h0000_007D;
	localparam logic [31:0] LEN_16_LIMIT    = 32'h0000_FFFF;
	localparam logic [6:0]  LEN_16_MARK     = 7'h7E;
	localparam logic [6:0]  LEN_64_MARK     = 7'h7F;
	localparam logic        FIN_BIT         = 1'b1;
	localparam logic        MASK_BIT        = 1'b1;

	// Byte index inside a header run and the last index of each class.
	localparam int HDR_IDX_W = 4;
	localparam logic [HDR_IDX_W-1:0] HDR_SHORT_LAST = 4'd5;
	localparam logic [HDR_IDX_W-1:0] HDR_16_LAST    = 4'd7;
	localparam logic [HDR_IDX_W-1:0] HDR_64_LAST    = 4'd13;
	localparam logic [HDR_IDX_W-1:0] HDR_64_LEN_IDX = 4'd6;

	// Default depth of the command queue between front and back end.
	localparam int QUEUE_DEPTH_DEF = 4;

	// One classified command as it travels from front to back end.
	typedef struct packed {
		logic        kind;
		logic [1:0]  len_class;
		logic [3:0]  opcode;
		logic [31:0] length;
		logic [31:0] key;
		logic [7:0]  data;
	} wsfe_entry_t;

	// Select byte number sel of a 32-bit word, byte 0 being least significant.
	function automatic logic [7:0] byte_of(logic [31:0] w, logic [1:0] sel);
		logic [7:0] b;
		case (sel)
			2'd0: b = w[7:0];
			2'd1: b = w[15:8];
			2'd2: b = w[23:16];
			default: b = w[31:24];
		endcase
		return b;
	endfunction

endpackage

// ===== hw/rtl/wsfe_front.sv =====
module wsfe_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 q_full,
	input  logic                 command,
	input  logic [31:0]          frame_length,
	input  logic [3:0]           frame_opcode,
	input  logic [31:0]          mask_key,
	input  logic [7:0]           payload_byte,
	output logic                 wr_en,
	output wsfe_pkg::wsfe_entry_t wr_entry
);

	logic [31:0] key_q;
	logic [1:0]  pos_q;
	logic [1:0]  len_class;

	assign wr_en = push && !q_full;

	// Classify the frame length into one of the three header forms.
	always_comb begin
		if (frame_length <= wsfe_pkg::LEN_SHORT_LIMIT) begin
			len_class = wsfe_pkg::LEN_CLASS_SHORT;
		end else if (frame_length <= wsfe_pkg::LEN_16_LIMIT) begin
			len_class = wsfe_pkg::LEN_CLASS_16;
		end else begin
			len_class = wsfe_pkg::LEN_CLASS_64;
		end
	end

	// Build the queue entry; payload bytes are masked here, in arrival order.
	always_comb begin
		wr_entry.kind      = command;
		wr_entry.len_class = len_class;
		wr_entry.opcode    = frame_opcode;
		wr_entry.length    = frame_length;
		wr_entry.key       = mask_key;
		wr_entry.data      = payload_byte ^ wsfe_pkg::byte_of(key_q, pos_q);
	end

	// Key store and mask position follow each accepted transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			pos_q <= '0;
		end else if (wr_en) begin
			if (command == wsfe_pkg::CMD_START) begin
				key_q <= mask_key;
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	a_start_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && command == wsfe_pkg::CMD_START) |=>
		(pos_q == 2'd0 && key_q == $past(mask_key)))
		else $error("mask position or key not set by frame start");

endmodule

// ===== hw/rtl/wsfe_queue.sv =====
module wsfe_queue #(
	parameter int DEPTH = wsfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  wsfe_pkg::wsfe_entry_t wr_entry,
	input  logic                  rd_en,
	output wsfe_pkg::wsfe_entry_t rd_entry,
	output logic                  full,
	output logic                  not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	wsfe_pkg::wsfe_entry_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign rd_entry  = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("command queue count beyond depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> not_empty)
		else $error("command queue read while empty");

endmodule

// ===== hw/rtl/wsfe_back.sv =====
module wsfe_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_not_empty,
	input  wsfe_pkg::wsfe_entry_t head,
	output logic                  rd_en,
	input  logic                  pop,
	output logic                  empty,
	output logic [7:0]            out_byte,
	output logic                  last_of_run
);

	logic [wsfe_pkg::HDR_IDX_W-1:0] idx_q;
	logic [wsfe_pkg::HDR_IDX_W-1:0] last_idx;
	logic [7:0] next_byte;
	logic       next_last;
	logic       out_valid_q;
	logic       out_free;
	logic       emit;

	// Next byte of the command at the head of the queue.
	always_comb begin
		next_byte = 8'h00;
		last_idx  = wsfe_pkg::HDR_SHORT_LAST;
		if (head.kind == wsfe_pkg::CMD_PAYLOAD) begin
			next_byte = head.data;
			next_last = 1'b1;
		end else begin
			case (head.len_class)
				wsfe_pkg::LEN_CLASS_SHORT: begin
					last_idx = wsfe_pkg::HDR_SHORT_LAST;
					if (idx_q == 4'd0) begin
						next_byte = {wsfe_pkg::FIN_BIT, 3'b000, head.opcode};
					end else if (idx_q == 4'd1) begin
						next_byte = {wsfe_pkg::MASK_BIT, head.length[6:0]};
					end else begin
						next_byte = wsfe_pkg::byte_of(head.key, idx_q[1:0] - 2'd2);
					end
				end
				wsfe_pkg::LEN_CLASS_16: begin
					last_idx = wsfe_pkg::HDR_16_LAST;
					if (idx_q == 4'd0) begin
						next_byte = {wsfe_pkg::FIN_BIT, 3'b000, head.opcode};
					end else if (idx_q == 4'd1) begin
						next_byte = {wsfe_pkg::MASK_BIT, wsfe_pkg::LEN_16_MARK};
					end else if (idx_q == 4'd2) begin
						next_byte = head.length[15:8];
					end else if (idx_q == 4'd3) begin
						next_byte = head.length[7:0];
					end else begin
						next_byte = wsfe_pkg::byte_of(head.key, idx_q[1:0]);
					end
				end
				default: begin
					// 64-bit length: four zero bytes, then the 32-bit length big-endian.
					last_idx = wsfe_pkg::HDR_64_LAST;
					if (idx_q == 4'd0) begin
						next_byte = {wsfe_pkg::FIN_BIT, 3'b000, head.opcode};
					end else if (idx_q == 4'd1) begin
						next_byte = {wsfe_pkg::MASK_BIT, wsfe_pkg::LEN_64_MARK};
					end else if (idx_q < wsfe_pkg::HDR_64_LEN_IDX) begin
						next_byte = 8'h00;
					end else if (idx_q < 4'd10) begin
						next_byte = wsfe_pkg::byte_of(head.length, 2'd1 - idx_q[1:0]);
					end else begin
						next_byte = wsfe_pkg::byte_of(head.key, idx_q[1:0] - 2'd2);
					end
				end
			endcase
			next_last = (idx_q == last_idx);
		end
	end

	// A byte moves into the output register whenever the queue holds a command and that register is free or drained.
	assign out_free = !out_valid_q || pop;
	assign emit     = q_not_empty && out_free;
	assign rd_en    = emit && next_last;
	assign empty    = !out_valid_q;

	// Header byte counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (emit) begin
			idx_q <= next_last ? '0 : idx_q + 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte    <= next_byte;
			last_of_run <= next_last;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= wsfe_pkg::HDR_64_LAST)
		else $error("header byte index out of range");

	a_mid_run_head: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != '0) |-> (q_not_empty && head.kind == wsfe_pkg::CMD_START))
		else $error("header run in progress without a start command at the head");

endmodule

// ===== hw/rtl/websocket_frame_encoder.sv =====
// A payload byte passes through the command queue and the output register to out_byte.
// A frame start yields a header run of 6, 8 or 14 bytes, set by the length form, one
// per cycle while the output is free; its command leaves the queue with the last byte.
// Throughput: one payload byte per cycle while pop is high; the queue absorbs bursts.
// Reset: arst_n clears the queue, the output register, the key and the mask position.
module websocket_frame_encoder #(
	parameter int QUEUE_DEPTH = wsfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        command,
	input  logic [31:0] frame_length,
	input  logic [3:0]  frame_opcode,
	input  logic [31:0] mask_key,
	input  logic [7:0]  payload_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        last_of_run
);

	wsfe_pkg::wsfe_entry_t wr_entry;
	wsfe_pkg::wsfe_entry_t rd_entry;
	logic wr_en;
	logic rd_en;
	logic q_not_empty;

	// Front end: classify and mask.
	wsfe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.q_full       (full),
		.command      (command),
		.frame_length (frame_length),
		.frame_opcode (frame_opcode),
		.mask_key     (mask_key),
		.payload_byte (payload_byte),
		.wr_en        (wr_en),
		.wr_entry     (wr_entry)
	);

	// Command queue between the two ends.
	wsfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_entry  (wr_entry),
		.rd_en     (rd_en),
		.rd_entry  (rd_entry),
		.full      (full),
		.not_empty (q_not_empty)
	);

	// Back end: header sequencing and output register.
	wsfe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (rd_entry),
		.rd_en       (rd_en),
		.pop         (pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule
